/* hw/rtl/i2cm_pkg.sv */
// Shared types, command codes and phase tables for the I2C master bit engine.
package i2cm_pkg;

  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_WAIT  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_PROBE = 3'd5;
  localparam logic [2:0] CMD_IDLE  = 3'd7;

  localparam int PHASE_W     = 6;
  localparam int TICK_W      = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = TICK_W'(1);

  typedef struct packed {
    logic       go;
    logic [2:0] req;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } result_t;

  function automatic logic [PHASE_W-1:0] phase_total(input logic [2:0] c);
    logic [PHASE_W-1:0] r;
    case (c)
      CMD_START: r = PHASE_W'(3);
      CMD_STOP:  r = PHASE_W'(2);
      CMD_WRITE: r = PHASE_W'(24);
      CMD_WAIT:  r = PHASE_W'(3);
      CMD_READ:  r = PHASE_W'(19);
      CMD_PROBE: r = PHASE_W'(32);
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/i2cm_in_if.sv */
// Input channel: one tick item with command, operands and SDA sample.
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] req_type;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd_valid, req_type, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, cmd_valid, req_type, tx_byte, send_ack, sda_in, output ready);
endinterface

/* hw/rtl/i2cm_out_if.sv */
// Output channel: pin levels and status for one tick.
interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_missing;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_missing,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_missing,
                  output ready);
endinterface

/* hw/rtl/i2cm_front.sv */
// Front stage: accept tick items, classify the command and register them.
module i2cm_front (
  input  logic              clk,
  input  logic              rst,
  i2cm_in_if.sink           ingress,
  output i2cm_pkg::item_t   item,
  output logic              item_valid,
  input  logic              item_ready
);

  i2cm_pkg::item_t classified;

  always_comb begin
    classified.go       = ingress.cmd_valid && (ingress.req_type <= i2cm_pkg::CMD_PROBE);
    classified.req      = ingress.req_type;
    classified.tx_byte  = ingress.tx_byte;
    classified.send_ack = ingress.send_ack;
    classified.sda_in   = ingress.sda_in;
  end

  assign ingress.ready = !item_valid || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (ingress.ready) begin
      item_valid <= ingress.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ingress.valid && ingress.ready) begin
      item <= classified;
    end
  end

endmodule

/* hw/rtl/i2cm_queue.sv */
// Short queue between the front stage and the bit engine.
module i2cm_queue #(
  parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  i2cm_pkg::item_t push_item,
  input  logic            push_valid,
  output logic            push_ready,
  output i2cm_pkg::item_t pop_item,
  output logic            pop_valid,
  input  logic            pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  i2cm_pkg::item_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count above depth");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (rd_ptr == wr_ptr)) else $error("empty queue with pointers apart");
  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == CNT_W'(DEPTH)) |-> (rd_ptr == wr_ptr)) else $error("full queue with pointers apart");
`endif

endmodule

/* hw/rtl/i2cm_engine.sv */
// Back stage: run the command phase sequencer one tick per item and register results.
module i2cm_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [i2cm_pkg::TICK_W-1:0]         cfg_wdata,
  input  i2cm_pkg::item_t                     item,
  input  logic                                item_valid,
  output logic                                item_ready,
  i2cm_out_if.source                          egress
);

  localparam int PW = i2cm_pkg::PHASE_W;
  localparam int TW = i2cm_pkg::TICK_W;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] shift;
  } levels_t;

  function automatic logic [63:0] mod3_tab();
    logic [63:0] t;
    t = '0;
    for (int i = 0; i < 32; i++) begin
      t[2*i +: 2] = 2'(i % 3);
    end
    return t;
  endfunction

  localparam logic [63:0] MOD3_TAB = mod3_tab();

  function automatic levels_t seg_start(input logic [1:0] q, input levels_t cur);
    levels_t r;
    r = cur;
    if (q == 2'd0) begin
      r.sda = 1'b1;
      r.scl = 1'b1;
    end else if (q == 2'd1) begin
      r.sda = 1'b0;
    end else begin
      r.scl = 1'b0;
    end
    return r;
  endfunction

  function automatic levels_t seg_stop(input logic q, input levels_t cur);
    levels_t r;
    r = cur;
    if (!q) begin
      r.sda = 1'b0;
      r.scl = 1'b1;
    end else begin
      r.sda = 1'b1;
    end
    return r;
  endfunction

  function automatic levels_t seg_write(input logic [4:0] q, input levels_t cur);
    levels_t    r;
    logic [1:0] s;
    r = cur;
    s = MOD3_TAB[{q, 1'b0} +: 2];
    if (s == 2'd0) begin
      r.sda = cur.shift[7];
    end else if (s == 2'd1) begin
      r.scl = 1'b1;
    end else begin
      r.scl = 1'b0;
      if (q == 5'd23) begin
        r.sda = 1'b1;
      end
      r.shift = {cur.shift[6:0], 1'b0};
    end
    return r;
  endfunction

  function automatic levels_t seg_wait(input logic [1:0] q, input levels_t cur);
    levels_t r;
    r = cur;
    if (q == 2'd0) begin
      r.sda = 1'b1;
    end else if (q == 2'd1) begin
      r.scl = 1'b1;
    end else begin
      r.scl = 1'b0;
    end
    return r;
  endfunction

  function automatic levels_t seg_read(input logic [4:0] q, input logic ackl,
                                       input levels_t cur);
    levels_t r;
    r = cur;
    if (q < 5'd16) begin
      r.scl = !q[0];
    end else if (q == 5'd16) begin
      r.sda = !ackl;
    end else if (q == 5'd17) begin
      r.scl = 1'b1;
    end else begin
      r.scl = 1'b0;
    end
    return r;
  endfunction

  function automatic levels_t enter_phase(input logic [2:0] c, input logic [PW-1:0] p,
                                          input logic ackl, input levels_t cur);
    levels_t       r;
    logic [PW-1:0] d;
    r = cur;
    d = '0;
    case (c)
      i2cm_pkg::CMD_START: r = seg_start(p[1:0], cur);
      i2cm_pkg::CMD_STOP:  r = seg_stop(p[0], cur);
      i2cm_pkg::CMD_WRITE: r = seg_write(p[4:0], cur);
      i2cm_pkg::CMD_WAIT:  r = seg_wait(p[1:0], cur);
      i2cm_pkg::CMD_READ:  r = seg_read(p[4:0], ackl, cur);
      i2cm_pkg::CMD_PROBE: begin
        if (p < PW'(3)) begin
          r = seg_start(p[1:0], cur);
        end else if (p < PW'(27)) begin
          d = p - PW'(3);
          r = seg_write(d[4:0], cur);
        end else if (p < PW'(30)) begin
          d = p - PW'(27);
          r = seg_wait(d[1:0], cur);
        end else begin
          d = p - PW'(30);
          r = seg_stop(d[0], cur);
        end
      end
      default: r = cur;
    endcase
    return r;
  endfunction

  logic [TW-1:0]  phase_ticks;
  logic [2:0]     cmd;
  logic [PW-1:0]  phase;
  logic [TW-1:0]  tick;
  levels_t        lv;
  logic [7:0]     rx_reg;
  logic           ack_flag;
  logic           ack_latched;
  logic           out_valid;
  i2cm_pkg::result_t out_res;

  logic [2:0]     cmd_next;
  logic [PW-1:0]  phase_next;
  logic [TW-1:0]  tick_next;
  levels_t        lv_next;
  logic [7:0]     rx_next;
  logic           ack_next;
  logic           ackl_next;
  i2cm_pkg::result_t res;
  logic           take;

  assign take       = item_valid && (!out_valid || egress.ready);
  assign item_ready = take;

  always_comb begin
    logic [2:0]    cmd_a;
    logic [PW-1:0] ph_a;
    logic [PW-1:0] ph_n;
    logic [TW-1:0] tk_a;
    logic [TW-1:0] tk_n;
    logic [TW-1:0] limit;
    levels_t       a;
    levels_t       e;
    logic          busy;
    logic          done;
    logic          adv;

    cmd_a     = cmd;
    ph_a      = phase;
    tk_a      = tick;
    a         = lv;
    ackl_next = ack_latched;
    if (cmd == i2cm_pkg::CMD_IDLE && item.go) begin
      cmd_a     = item.req;
      ph_a      = '0;
      tk_a      = '0;
      ackl_next = item.send_ack;
      a.shift   = (item.req == i2cm_pkg::CMD_READ) ? 8'h00 : item.tx_byte;
      a         = enter_phase(item.req, '0, item.send_ack, a);
    end

    busy  = (cmd_a != i2cm_pkg::CMD_IDLE);
    limit = (phase_ticks == '0) ? TW'(1) : phase_ticks;
    tk_n  = tk_a + TW'(1);
    adv   = busy && (tk_n >= limit);
    done  = 1'b0;
    ph_n  = ph_a + PW'(1);

    cmd_next   = cmd_a;
    phase_next = ph_a;
    tick_next  = busy ? (adv ? '0 : tk_n) : tk_a;
    rx_next    = rx_reg;
    ack_next   = ack_flag;
    e          = a;

    if (adv) begin
      if ((cmd_a == i2cm_pkg::CMD_WAIT && ph_a == PW'(1)) ||
          (cmd_a == i2cm_pkg::CMD_PROBE && ph_a == PW'(28))) begin
        ack_next = item.sda_in;
      end else if (cmd_a == i2cm_pkg::CMD_READ && ph_a < PW'(16) && !ph_a[0]) begin
        e.shift = {a.shift[6:0], item.sda_in};
        if (ph_a == PW'(14)) begin
          rx_next = e.shift;
        end
      end
      if (ph_n >= i2cm_pkg::phase_total(cmd_a)) begin
        if (cmd_a == i2cm_pkg::CMD_READ) begin
          e.sda = 1'b1;
        end
        done       = 1'b1;
        cmd_next   = i2cm_pkg::CMD_IDLE;
        phase_next = '0;
      end else begin
        e          = enter_phase(cmd_a, ph_n, ackl_next, e);
        phase_next = ph_n;
      end
    end
    lv_next = e;

    res.scl         = a.scl;
    res.sda         = a.sda;
    res.busy        = busy;
    res.done        = done;
    res.rx_byte     = rx_next;
    res.ack_missing = ack_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cm_pkg::PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      phase_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd         <= i2cm_pkg::CMD_IDLE;
      phase       <= '0;
      tick        <= '0;
      lv          <= '{scl: 1'b1, sda: 1'b1, shift: 8'h00};
      rx_reg      <= '0;
      ack_flag    <= 1'b0;
      ack_latched <= 1'b0;
    end else if (take) begin
      cmd         <= cmd_next;
      phase       <= phase_next;
      tick        <= tick_next;
      lv          <= lv_next;
      rx_reg      <= rx_next;
      ack_flag    <= ack_next;
      ack_latched <= ackl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (egress.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= res;
    end
  end

  assign egress.valid       = out_valid;
  assign egress.scl_out     = out_res.scl;
  assign egress.sda_out     = out_res.sda;
  assign egress.busy_res    = out_res.busy;
  assign egress.done_res    = out_res.done;
  assign egress.rx_byte     = out_res.rx_byte;
  assign egress.ack_missing = out_res.ack_missing;

`ifndef NO_ASSERTIONS
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.done) |-> out_res.busy) else $error("done without busy");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd == i2cm_pkg::CMD_IDLE) |-> (phase == '0 && tick == '0))
    else $error("idle with phase or tick left over");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (cmd != i2cm_pkg::CMD_IDLE) |-> (phase < i2cm_pkg::phase_total(cmd)))
    else $error("phase beyond command length");
`endif

endmodule

/* hw/rtl/i2c_master_bit_engine.sv */
// I2C master bit engine top level: front stage, queue and phase sequencer.
// Throughput: one tick transaction per cycle while the output is not stalled, one result transaction per tick.
// Path: a taken transaction passes the front register, a queue slot and the output register
// in that order before its result leaves.
// Reset: synchronous; engine idle, SCL and SDA released, phase_ticks 1, queue empty.
module i2c_master_bit_engine #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [i2cm_pkg::TICK_W-1:0] cfg_wdata,
  i2cm_in_if.sink                     ingress,
  i2cm_out_if.source                  egress
);

  i2cm_pkg::item_t front_item;
  logic            front_valid;
  logic            front_ready;
  i2cm_pkg::item_t queue_item;
  logic            queue_valid;
  logic            queue_ready;

  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .ingress    (ingress),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (queue_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready)
  );

  i2cm_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item       (queue_item),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .egress     (egress)
  );

endmodule

/* sim/tb.sv */
// Testbench for the I2C master bit engine: per-tick bus level prediction and checking.
module tb;
  import i2cm_pkg::*;

  localparam logic [2:0] REQ_UNUSED = 3'd6;
  localparam int IDLE_PCT = 21;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SDA_LOW = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RANDOM = 2;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [TICK_W-1:0] cfg_wdata;

  i2cm_in_if in_ch();
  i2cm_out_if out_ch();

  i2c_master_bit_engine dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .ingress(in_ch),
    .egress(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  result_t bus_tick_q[$];
  int mismatches = 0;
  int ticks_sent = 0;
  int cycle_count = 0;
  int hold_off_req = 0;
  bit steady = 1'b0;

  logic [15:0] hold_ticks = PHASE_TICKS_RESET;
  logic [2:0] cur_cmd = CMD_IDLE;
  logic [5:0] phase = '0;
  logic [7:0] shifter = '0;
  logic [15:0] tick_cnt = '0;
  logic scl_lvl = 1'b1;
  logic sda_lvl = 1'b1;
  logic [7:0] rx_hold = '0;
  logic ack_miss = 1'b0;
  logic ack_to_send = 1'b0;

  function automatic logic [5:0] phase_count(input logic [2:0] c);
    case (c)
      CMD_START: return 6'd3;
      CMD_STOP:  return 6'd2;
      CMD_WRITE: return 6'd24;
      CMD_WAIT:  return 6'd3;
      CMD_READ:  return 6'd19;
      CMD_PROBE: return 6'd32;
      default:   return 6'd0;
    endcase
  endfunction

  function automatic void start_cond(input logic [5:0] q);
    if (q == 0) begin
      sda_lvl = 1'b1;
      scl_lvl = 1'b1;
    end else if (q == 1) begin
      sda_lvl = 1'b0;
    end else begin
      scl_lvl = 1'b0;
    end
  endfunction

  function automatic void stop_cond(input logic [5:0] q);
    if (q == 0) begin
      sda_lvl = 1'b0;
      scl_lvl = 1'b1;
    end else begin
      sda_lvl = 1'b1;
    end
  endfunction

  function automatic void shift_out(input logic [5:0] q);
    logic [5:0] s;
    s = 6'(q % 3);
    if (s == 0) begin
      sda_lvl = shifter[7];
    end else if (s == 1) begin
      scl_lvl = 1'b1;
    end else begin
      scl_lvl = 1'b0;
      if (q / 3 == 7) sda_lvl = 1'b1;
      shifter = {shifter[6:0], 1'b0};
    end
  endfunction

  function automatic void ack_check(input logic [5:0] q);
    if (q == 0) sda_lvl = 1'b1;
    else if (q == 1) scl_lvl = 1'b1;
    else scl_lvl = 1'b0;
  endfunction

  function automatic void shift_in(input logic [5:0] q);
    if (q < 16) scl_lvl = ~q[0];
    else if (q == 16) sda_lvl = ~ack_to_send;
    else if (q == 17) scl_lvl = 1'b1;
    else scl_lvl = 1'b0;
  endfunction

  function automatic void enter_phase(input logic [2:0] c, input logic [5:0] p);
    case (c)
      CMD_START: start_cond(p);
      CMD_STOP:  stop_cond(p);
      CMD_WRITE: shift_out(p);
      CMD_WAIT:  ack_check(p);
      CMD_READ:  shift_in(p);
      CMD_PROBE: begin
        if (p < 3) start_cond(p);
        else if (p < 27) shift_out(p - 6'd3);
        else if (p < 30) ack_check(p - 6'd27);
        else stop_cond(p - 6'd30);
      end
      default: ;
    endcase
  endfunction

  function automatic void leave_phase(input logic [2:0] c, input logic [5:0] p, input logic sda);
    if ((c == CMD_WAIT && p == 1) || (c == CMD_PROBE && p == 28)) begin
      ack_miss = sda;
    end else if (c == CMD_READ && p < 16 && !p[0]) begin
      shifter = {shifter[6:0], sda};
      if (p == 14) rx_hold = shifter;
    end
  endfunction

  function automatic result_t predict_bus_tick(input item_t it);
    result_t r;
    logic [15:0] limit;
    if (cur_cmd == CMD_IDLE && it.go && it.req <= CMD_PROBE) begin
      cur_cmd = it.req;
      phase = '0;
      tick_cnt = '0;
      shifter = (it.req == CMD_READ) ? 8'h00 : it.tx_byte;
      ack_to_send = it.send_ack;
      enter_phase(cur_cmd, phase);
    end
    r = '0;
    r.scl = scl_lvl;
    r.sda = sda_lvl;
    if (cur_cmd != CMD_IDLE) begin
      r.busy = 1'b1;
      limit = (hold_ticks == 0) ? 16'd1 : hold_ticks;
      tick_cnt = tick_cnt + 16'd1;
      if (tick_cnt >= limit) begin
        tick_cnt = '0;
        leave_phase(cur_cmd, phase, it.sda_in);
        phase = phase + 6'd1;
        if (phase >= phase_count(cur_cmd)) begin
          if (cur_cmd == CMD_READ) sda_lvl = 1'b1;
          r.done = 1'b1;
          cur_cmd = CMD_IDLE;
          phase = '0;
        end else begin
          enter_phase(cur_cmd, phase);
        end
      end
    end
    r.rx_byte = rx_hold;
    r.ack_missing = ack_miss;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    if (mismatches < 50)
      $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (bus_tick_q.size() == 0) begin
        report_mismatch("transaction with none pending", 8'd1, 8'd0);
      end else begin
        want = bus_tick_q.pop_front();
        check_field("scl_out", 8'(out_ch.scl_out), 8'(want.scl));
        check_field("sda_out", 8'(out_ch.sda_out), 8'(want.sda));
        check_field("busy_res", 8'(out_ch.busy_res), 8'(want.busy));
        check_field("done_res", 8'(out_ch.done_res), 8'(want.done));
        check_field("rx_byte", out_ch.rx_byte, want.rx_byte);
        check_field("ack_missing", 8'(out_ch.ack_missing), 8'(want.ack_missing));
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req != 0) begin
        out_ch.ready <= 1'b0;
        hold_off_req = hold_off_req - 1;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic item_t make_tick(input logic go, input logic [2:0] req,
                                      input logic [7:0] txb, input logic sack,
                                      input int sda_mode);
    item_t it;
    it.go = go;
    it.req = req;
    it.tx_byte = txb;
    it.send_ack = sack;
    it.sda_in = (sda_mode == SDA_RANDOM) ? 1'($urandom_range(1)) : sda_mode[0];
    return it;
  endfunction

  task automatic send_tick(input item_t it);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd_valid <= it.go;
    in_ch.req_type <= it.req;
    in_ch.tx_byte <= it.tx_byte;
    in_ch.send_ack <= it.send_ack;
    in_ch.sda_in <= it.sda_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bus_tick_q.push_back(predict_bus_tick(it));
    ticks_sent++;
  endtask

  task automatic idle_ticks(input int n);
    repeat (n)
      send_tick(make_tick(1'b0, 3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                          SDA_RANDOM));
  endtask

  task automatic run_command(input logic [2:0] req, input logic [7:0] txb, input logic sack,
                             input int sda_mode, input int noise_pct);
    send_tick(make_tick(1'b1, req, txb, sack, sda_mode));
    while (cur_cmd != CMD_IDLE)
      send_tick(make_tick($urandom_range(99) < noise_pct, 3'($urandom_range(7)), 8'($urandom),
                          1'($urandom_range(1)), sda_mode));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (bus_tick_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_phase_ticks(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    hold_ticks = v;
  endtask

  task automatic test_reset_levels();
    idle_ticks(6);
  endtask

  task automatic test_unknown_requests();
    run_command(REQ_UNUSED, 8'hFF, 1'b1, SDA_LOW, 0);
    run_command(CMD_IDLE, 8'h00, 1'b0, SDA_HIGH, 0);
    idle_ticks(2);
  endtask

  task automatic test_each_command();
    drain();
    write_phase_ticks(16'd1);
    run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_command(CMD_WRITE, 8'hFF, 1'b0, SDA_RANDOM, 0);
    run_command(CMD_WAIT, 8'h00, 1'b0, SDA_LOW, 0);
    run_command(CMD_WRITE, 8'h00, 1'b1, SDA_RANDOM, 0);
    run_command(CMD_WAIT, 8'hFF, 1'b1, SDA_HIGH, 0);
    run_command(CMD_READ, 8'hFF, 1'b1, SDA_RANDOM, 0);
    run_command(CMD_READ, 8'h00, 1'b0, SDA_HIGH, 0);
    run_command(CMD_READ, 8'hFF, 1'b1, SDA_LOW, 0);
    run_command(CMD_PROBE, 8'hA1, 1'b0, SDA_LOW, 0);
    run_command(CMD_PROBE, 8'h40, 1'b1, SDA_HIGH, 0);
    run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
  endtask

  task automatic test_offer_while_busy();
    run_command(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 100);
    run_command(CMD_READ, 8'h3C, 1'b1, SDA_RANDOM, 100);
  endtask

  task automatic test_phase_ticks_values();
    drain();
    write_phase_ticks(16'd0);
    run_command(CMD_WRITE, 8'h5A, 1'b0, SDA_RANDOM, 10);
    run_command(CMD_PROBE, 8'hA1, 1'b0, SDA_RANDOM, 10);
    drain();
    write_phase_ticks(16'd3);
    run_command(CMD_READ, 8'h00, 1'b0, SDA_RANDOM, 10);
    run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 10);
    drain();
    write_phase_ticks(16'd2);
    run_command(CMD_PROBE, 8'h7E, 1'b1, SDA_RANDOM, 10);
    run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 10);
  endtask

  task automatic test_longest_phase();
    drain();
    write_phase_ticks(16'hFFFF);
    steady = 1'b1;
    send_tick(make_tick(1'b1, CMD_START, 8'($urandom), 1'b0, SDA_RANDOM));
    idle_ticks(40);
    drain();
    write_phase_ticks(16'd1);
    while (cur_cmd != CMD_IDLE) idle_ticks(1);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int settings[8] = '{1, 2, 1, 5, 1, 2, 1, 3};
    int phase_start;
    foreach (settings[i]) begin
      drain();
      write_phase_ticks(16'(settings[i]));
      steady = (i == 2);
      if (i == 4) hold_off_req = 400;
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < 140) begin
        if ($urandom_range(99) < 5)
          run_command(3'($urandom_range(6, 7)), 8'($urandom), 1'($urandom_range(1)),
                      SDA_RANDOM, 0);
        else
          run_command(3'($urandom_range(5)), 8'($urandom), 1'($urandom_range(1)),
                      SDA_RANDOM, 10);
        idle_ticks($urandom_range(3));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd_valid <= 1'b0;
    in_ch.req_type <= CMD_START;
    in_ch.tx_byte <= '0;
    in_ch.send_ack <= 1'b0;
    in_ch.sda_in <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_levels();
    test_unknown_requests();
    test_each_command();
    test_offer_while_busy();
    test_phase_ticks_values();
    test_longest_phase();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_in_if.sv
hw/rtl/i2cm_out_if.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_queue.sv
hw/rtl/i2cm_engine.sv
hw/rtl/i2c_master_bit_engine.sv
sim/tb.sv
